>>> src/ust_pkg.sv
// shared constants and types for the union-find spanning tree engine
// no dependencies; imported by ust_geom, the top level and ust_checker
`default_nettype none

package ust_pkg;

    // table geometry
    localparam int MAX_CELLS = 4096;
    localparam int MAX_SIDE  = 64;
    localparam int CELL_W    = $clog2(MAX_CELLS);

    // item field widths
    localparam int COORD_W = 6;
    localparam int SIDE_W  = 7;
    localparam int COUNT_W = 12;

    // union by rank
    localparam int RANK_W   = 4;
    localparam int RANK_MAX = 15;

    // wide enough for row * width + col plus one step right or down
    localparam int IDX_W   = (CELL_W >= COORD_W + SIDE_W) ? CELL_W + 1 : COORD_W + SIDE_W + 1;
    localparam int CELLS_W = 2 * SIDE_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

    // request codes
    localparam logic REQ_CLEAR = 1'b0;
    localparam logic REQ_EDGE  = 1'b1;

    // one union-find table entry
    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [CELL_W-1:0] parent;
    } entry_t;

    localparam int ENTRY_W = RANK_W + CELL_W;

    // geometry of the current item, as seen by the sequencer
    typedef struct packed {
        logic               off;
        logic [CELL_W-1:0]  idx_a;
        logic [CELL_W-1:0]  idx_b;
        logic [CELLS_W-1:0] cells;
    } geom_t;

endpackage

`default_nettype wire

>>> src/ust_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module ust_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/ust_geom.sv
// grid configuration registers and cell index / off-grid computation
// depends on ust_pkg
`default_nettype none

module ust_geom
    import ust_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIDE_W-1:0]    cfg_wdata,
    input  wire logic                 load,
    input  wire logic [COORD_W-1:0]   cell_row,
    input  wire logic [COORD_W-1:0]   cell_col,
    input  wire logic                 edge_dir,
    output geom_t                     geom
);

    logic [SIDE_W-1:0]  grid_width_reg;
    logic [SIDE_W-1:0]  grid_height_reg;
    logic [CELLS_W-1:0] cells_reg;
    logic               off_reg;
    logic [CELL_W-1:0]  idx_a_reg;
    logic [CELL_W-1:0]  idx_b_reg;

    logic [SIDE_W-1:0] w_eff;
    logic [SIDE_W-1:0] h_eff;
    logic [SIDE_W-1:0] row_x;
    logic [SIDE_W-1:0] col_x;
    logic [SIDE_W-1:0] row2;
    logic [SIDE_W-1:0] col2;
    logic [IDX_W-1:0]  idx_a;
    logic [IDX_W-1:0]  idx_b;
    logic              off;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= SIDE_W'(MAX_SIDE);
            grid_height_reg <= SIDE_W'(MAX_SIDE);
        end else if (cfg_wr_en) begin
            if (cfg_index == CFG_GRID_WIDTH) begin
                grid_width_reg <= cfg_wdata;
            end
            if (cfg_index == CFG_GRID_HEIGHT) begin
                grid_height_reg <= cfg_wdata;
            end
        end
    end

    // sides above the table limit are clamped
    assign w_eff = (grid_width_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_width_reg;
    assign h_eff = (grid_height_reg > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : grid_height_reg;

    assign row_x = SIDE_W'(cell_row);
    assign col_x = SIDE_W'(cell_col);
    assign row2  = row_x + SIDE_W'(edge_dir);
    assign col2  = col_x + SIDE_W'(!edge_dir);

    // row-major index; the neighbor is one column or one row further
    assign idx_a = IDX_W'(cell_row) * IDX_W'(w_eff) + IDX_W'(cell_col);
    assign idx_b = idx_a + (edge_dir ? IDX_W'(w_eff) : IDX_W'(1));

    assign off = (row_x >= h_eff) || (col_x >= w_eff) || (row2 >= h_eff) || (col2 >= w_eff)
              || (idx_a >= IDX_W'(MAX_CELLS)) || (idx_b >= IDX_W'(MAX_CELLS));

    always_ff @(posedge aclk) begin
        cells_reg <= CELLS_W'(w_eff) * CELLS_W'(h_eff);
        if (load) begin
            off_reg   <= off;
            idx_a_reg <= idx_a[CELL_W-1:0];
            idx_b_reg <= idx_b[CELL_W-1:0];
        end
    end

    assign geom.off   = off_reg;
    assign geom.idx_a = idx_a_reg;
    assign geom.idx_b = idx_b_reg;
    assign geom.cells = cells_reg;

endmodule

`default_nettype wire

>>> src/union_find_spanning_tree.sv
// top level of the union-find spanning tree engine: sequencer and output register
// depends on ust_pkg, ust_geom and ust_ram
`default_nettype none

// Kruskal spanning-tree engine over a grid of up to 64 x 64 cells. Each edge item
// names a cell and a direction (right or down); the block finds both roots in a
// union-find table with full path compression, unites different roots by rank and
// returns one result item per input item. The parent and rank of every cell share
// one synchronous ram entry, read once per cycle. An edge walks each cell's parent
// chain to its root and then again to compress it, links the two roots, bumps the
// surviving root's rank when ranks are equal and below the top, and loads the result.
// An off-grid edge, or any edge once the tree is done, skips the search. After reset,
// and for every clear item, the table is rewritten one entry a cycle, all 4096 entries,
// while no item is taken (grid size writes still are). The clear item's result follows the pass.
// A new item is accepted while the previous result still waits on the output; a
// result that finds the output register still full waits there, holding the input.

module union_find_spanning_tree
    import ust_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    // configuration
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIDE_W-1:0]    cfg_wdata,

    // request items
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_req_type,
    input  wire logic [COORD_W-1:0]   s_cell_row,
    input  wire logic [COORD_W-1:0]   s_cell_col,
    input  wire logic                 s_edge_dir,

    // result items
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic                      m_carve_wall,
    output logic      [COORD_W-1:0]   m_out_row,
    output logic      [COORD_W-1:0]   m_out_col,
    output logic                      m_out_dir,
    output logic                      m_off_grid,
    output logic                      m_tree_done,
    output logic      [COUNT_W-1:0]   m_edges_added
);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;  // table sweep after reset or clear item
    localparam logic [3:0] S_IDLE  = 4'd1;  // waiting for an item
    localparam logic [3:0] S_CHECK = 4'd2;  // geometry known, decide whether to search
    localparam logic [3:0] S_START = 4'd3;  // issue read of the start cell of one side
    localparam logic [3:0] S_FIND  = 4'd4;  // walk the parent chain up to the root
    localparam logic [3:0] S_COMP  = 4'd5;  // walk again, pointing each node at the root
    localparam logic [3:0] S_LINK  = 4'd6;  // hang the lower-rank root under the other
    localparam logic [3:0] S_RANK  = 4'd7;  // bump the rank of the surviving root
    localparam logic [3:0] S_RESP  = 4'd8;  // load the output register

    localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(MAX_CELLS - 1);

    logic [3:0]         state_reg,     state_next;
    logic [CELL_W-1:0]  clr_cnt_reg,   clr_cnt_next;
    logic               clr_resp_reg,  clr_resp_next;
    logic               side_reg,      side_next;
    logic [CELL_W-1:0]  cur_reg,       cur_next;
    logic [CELL_W-1:0]  root_reg,      root_next;
    logic [RANK_W-1:0]  root_rank_reg, root_rank_next;
    logic [CELL_W-1:0]  ra_reg,        ra_next;
    logic [RANK_W-1:0]  rank_a_reg,    rank_a_next;
    logic [CELL_W-1:0]  hi_reg,        hi_next;
    logic [RANK_W-1:0]  hi_rank_reg,   hi_rank_next;
    logic               carve_reg,     carve_next;
    logic [COUNT_W-1:0] edge_cnt_reg,  edge_cnt_next;

    // latched item
    logic               req_reg,       req_next;
    logic [COORD_W-1:0] row_reg,       row_next;
    logic [COORD_W-1:0] col_reg,       col_next;
    logic               dir_reg,       dir_next;

    // output register
    logic               m_valid_reg,   m_valid_next;
    logic               m_carve_reg,   m_carve_next;
    logic [COORD_W-1:0] m_row_reg,     m_row_next;
    logic [COORD_W-1:0] m_col_reg,     m_col_next;
    logic               m_dir_reg,     m_dir_next;
    logic               m_off_reg,     m_off_next;
    logic               m_done_reg,    m_done_next;
    logic [COUNT_W-1:0] m_edges_reg,   m_edges_next;

    // ram port
    logic               ram_we;
    logic [CELL_W-1:0]  ram_waddr;
    entry_t             ram_wdata;
    logic [CELL_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t             rd_entry;

    geom_t              geom;
    logic               accept;
    logic               tree_done;
    logic [CELL_W-1:0]  start_idx;
    logic               swap;
    logic [CELL_W-1:0]  link_hi;
    logic [CELL_W-1:0]  link_lo;
    logic [RANK_W-1:0]  link_hi_rank;
    logic [RANK_W-1:0]  link_lo_rank;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    ust_geom u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .load      (accept),
        .cell_row  (s_cell_row),
        .cell_col  (s_cell_col),
        .edge_dir  (s_edge_dir),
        .geom      (geom)
    );

    ust_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_CELLS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign rd_entry = entry_t'(ram_rdata);

    // done once cells-1 edges are in; an empty grid is never done
    assign tree_done = (geom.cells != '0)
                    && (CELLS_W'(edge_cnt_reg) >= geom.cells - CELLS_W'(1));

    assign start_idx = side_reg ? geom.idx_b : geom.idx_a;

    // union by rank: root b is root_reg, root a was saved after the first search
    assign swap         = (rank_a_reg < root_rank_reg);
    assign link_hi      = swap ? root_reg : ra_reg;
    assign link_lo      = swap ? ra_reg : root_reg;
    assign link_hi_rank = swap ? root_rank_reg : rank_a_reg;
    assign link_lo_rank = swap ? rank_a_reg : root_rank_reg;

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_resp_next  = clr_resp_reg;
        side_next      = side_reg;
        cur_next       = cur_reg;
        root_next      = root_reg;
        root_rank_next = root_rank_reg;
        ra_next        = ra_reg;
        rank_a_next    = rank_a_reg;
        hi_next        = hi_reg;
        hi_rank_next   = hi_rank_reg;
        carve_next     = carve_reg;
        edge_cnt_next  = edge_cnt_reg;
        req_next       = req_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        dir_next       = dir_reg;

        m_valid_next   = m_valid_reg && !m_ready;
        m_carve_next   = m_carve_reg;
        m_row_next     = m_row_reg;
        m_col_next     = m_col_reg;
        m_dir_next     = m_dir_reg;
        m_off_next     = m_off_reg;
        m_done_next    = m_done_reg;
        m_edges_next   = m_edges_reg;

        ram_we         = 1'b0;
        ram_waddr      = cur_reg;
        ram_wdata      = '0;
        ram_raddr      = cur_reg;

        unique case (state_reg)
            S_CLEAR: begin
                // every entry becomes its own root with rank zero
                ram_we           = 1'b1;
                ram_waddr        = clr_cnt_reg;
                ram_wdata.rank   = '0;
                ram_wdata.parent = clr_cnt_reg;
                if (clr_cnt_reg == LAST_CELL) begin
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + CELL_W'(1);
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_type;
                    row_next   = s_cell_row;
                    col_next   = s_cell_col;
                    dir_next   = s_edge_dir;
                    carve_next = 1'b0;
                    if (s_req_type == REQ_CLEAR) begin
                        edge_cnt_next = '0;
                        clr_cnt_next  = '0;
                        clr_resp_next = 1'b1;
                        state_next    = S_CLEAR;
                    end else begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (geom.off || tree_done) begin
                    state_next = S_RESP;
                end else begin
                    side_next  = 1'b0;
                    state_next = S_START;
                end
            end
            S_START: begin
                ram_raddr  = start_idx;
                cur_next   = start_idx;
                state_next = S_FIND;
            end
            S_FIND: begin
                if (rd_entry.parent == cur_reg) begin
                    // root reached: restart from the first cell to compress
                    root_next      = cur_reg;
                    root_rank_next = rd_entry.rank;
                    ram_raddr      = start_idx;
                    cur_next       = start_idx;
                    state_next     = S_COMP;
                end else begin
                    ram_raddr = rd_entry.parent;
                    cur_next  = rd_entry.parent;
                end
            end
            S_COMP: begin
                if (cur_reg == root_reg) begin
                    if (!side_reg) begin
                        ra_next     = root_reg;
                        rank_a_next = root_rank_reg;
                        side_next   = 1'b1;
                        state_next  = S_START;
                    end else begin
                        state_next = S_LINK;
                    end
                end else begin
                    // write and next read never hit the same entry: chains hold no repeats
                    ram_we           = 1'b1;
                    ram_waddr        = cur_reg;
                    ram_wdata.rank   = rd_entry.rank;
                    ram_wdata.parent = root_reg;
                    ram_raddr        = rd_entry.parent;
                    cur_next         = rd_entry.parent;
                end
            end
            S_LINK: begin
                if (ra_reg == root_reg) begin
                    state_next = S_RESP;
                end else begin
                    ram_we           = 1'b1;
                    ram_waddr        = link_lo;
                    ram_wdata.rank   = link_lo_rank;
                    ram_wdata.parent = link_hi;
                    carve_next       = 1'b1;
                    edge_cnt_next    = edge_cnt_reg + COUNT_W'(1);
                    hi_next          = link_hi;
                    hi_rank_next     = link_hi_rank;
                    // equal ranks grow the new root, saturating at the top
                    if ((link_hi_rank == link_lo_rank)
                        && (link_hi_rank < RANK_W'(RANK_MAX))) begin
                        state_next = S_RANK;
                    end else begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RANK: begin
                ram_we           = 1'b1;
                ram_waddr        = hi_reg;
                ram_wdata.rank   = hi_rank_reg + RANK_W'(1);
                ram_wdata.parent = hi_reg;
                state_next       = S_RESP;
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_carve_next = carve_reg;
                    m_row_next   = carve_reg ? row_reg : '0;
                    m_col_next   = carve_reg ? col_reg : '0;
                    m_dir_next   = carve_reg && dir_reg;
                    m_off_next   = (req_reg == REQ_EDGE) && geom.off;
                    m_done_next  = tree_done;
                    m_edges_next = edge_cnt_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            edge_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            edge_cnt_reg <= edge_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge aclk) begin
        side_reg      <= side_next;
        cur_reg       <= cur_next;
        root_reg      <= root_next;
        root_rank_reg <= root_rank_next;
        ra_reg        <= ra_next;
        rank_a_reg    <= rank_a_next;
        hi_reg        <= hi_next;
        hi_rank_reg   <= hi_rank_next;
        carve_reg     <= carve_next;
        req_reg       <= req_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        dir_reg       <= dir_next;
        m_carve_reg   <= m_carve_next;
        m_row_reg     <= m_row_next;
        m_col_reg     <= m_col_next;
        m_dir_reg     <= m_dir_next;
        m_off_reg     <= m_off_next;
        m_done_reg    <= m_done_next;
        m_edges_reg   <= m_edges_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_carve_wall  = m_carve_reg;
    assign m_out_row     = m_row_reg;
    assign m_out_col     = m_col_reg;
    assign m_out_dir     = m_dir_reg;
    assign m_off_grid    = m_off_reg;
    assign m_tree_done   = m_done_reg;
    assign m_edges_added = m_edges_reg;

endmodule

`default_nettype wire

>>> src/ust_checker.sv
// port-level assertions for the union-find spanning tree engine, bound to the top level
// depends on ust_pkg
`default_nettype none

module ust_checker
    import ust_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic                 m_carve_wall,
    input wire logic [COORD_W-1:0]   m_out_row,
    input wire logic [COORD_W-1:0]   m_out_col,
    input wire logic                 m_out_dir,
    input wire logic                 m_off_grid,
    input wire logic                 m_tree_done,
    input wire logic [COUNT_W-1:0]   m_edges_added
);

    // one item in flight: an accepted item closes the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after an accepted item");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_carve_wall) && $stable(m_edges_added)
                                && $stable(m_off_grid) && $stable(m_tree_done))
        else $error("stalled result changed");

    // an off-grid edge is never carved
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_carve_wall |-> !m_off_grid)
        else $error("carved an off-grid edge");

    // uncarved results carry zero coordinates
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_carve_wall |-> (m_out_row == '0) && (m_out_col == '0) && !m_out_dir)
        else $error("coordinates on an uncarved result");

    // a carve always leaves at least one edge counted
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_carve_wall |-> m_edges_added != '0)
        else $error("carve with zero edge count");

endmodule

bind union_find_spanning_tree ust_checker u_checker (.*);

`default_nettype wire
